>>> rtl/core/unab_pkg.sv
package unab_pkg;

    // Payload widths
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned CSUM_W  = 16;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned VB_W    = 4;
    localparam int unsigned BEAT_W  = 4;

    // Beat sequencing
    localparam logic [BEAT_W-1:0] LAST_BEAT   = 4'd10;
    localparam logic [VB_W-1:0]   FULL_BYTES  = 4'd8;
    localparam logic [VB_W-1:0]   TAIL_BYTES  = 4'd6;

    // Checksum: fixed 16-bit words of pseudo-header and message
    // (ff02 + 0001 + length 32 + next header 58 + type/code 8800
    //  + flags a000 + option 0201)
    localparam int unsigned SUM_W   = 19;
    localparam int unsigned TOTAL_W = 21;
    localparam logic [SUM_W-1:0] CSUM_BASE = 19'h2295E;

    // Fixed frame bytes
    localparam logic [7:0] MCAST_33    = 8'h33;
    localparam logic [7:0] ALL_NODES   = 8'h01;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0] IP_VER      = 8'h60;
    localparam logic [7:0] PAY_LEN     = 8'd32;
    localparam logic [7:0] NH_ICMP6    = 8'd58;
    localparam logic [7:0] HOP_LIMIT   = 8'd255;
    localparam logic [15:0] DST_PREFIX = 16'hFF02;
    localparam logic [7:0] NA_TYPE     = 8'd136;
    localparam logic [7:0] NA_FLAGS    = 8'hA0;
    localparam logic [7:0] OPT_TLLA    = 8'd2;
    localparam logic [7:0] OPT_LEN     = 8'd1;

    // Register addresses (64-bit registers, 8-byte stride)
    localparam int unsigned PADDR_W = 4;
    localparam logic REG_MAC = 1'b0;

    // One address with its checksum, passed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [CSUM_W-1:0] csum;
    } t_job;

endpackage

>>> rtl/core/unab_front.sv
module unab_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [unab_pkg::ADDR_W-1:0] i_addr_high,
    input  logic [unab_pkg::ADDR_W-1:0] i_addr_low,
    input  logic [unab_pkg::MAC_W-1:0]  i_mac,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output unab_pkg::t_job              o_job
);
    import unab_pkg::*;

    logic                r_s1_valid;
    logic [ADDR_W-1:0]   r_addr_high;
    logic [ADDR_W-1:0]   r_addr_low;
    logic [SUM_W-1:0]    r_addr_sum;
    logic [SUM_W-1:0]    r_mac_sum;
    logic [SUM_W-1:0]    n_addr_sum;
    logic [SUM_W-1:0]    n_mac_sum;
    logic [TOTAL_W-1:0]  w_total;
    logic [16:0]         w_fold1;
    logic [15:0]         w_fold2;
    logic                w_take;

    assign o_full = r_s1_valid && !i_job_ready;
    assign w_take = i_push && !o_full;

    // Sum address words and the fixed words with the MAC
    always_comb begin
        logic [2*ADDR_W-1:0] addr;
        addr       = {i_addr_high, i_addr_low};
        n_addr_sum = '0;
        for (int k = 0; k < 8; k++) begin
            n_addr_sum = n_addr_sum + {3'b000, addr[16*k +: 16]};
        end
        n_mac_sum = CSUM_BASE + {3'b000, i_mac[47:32]} + {3'b000, i_mac[31:16]}
                    + {3'b000, i_mac[15:0]};
    end

    // Hold the accepted address and its partial sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_full) begin
            r_s1_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_addr_high <= i_addr_high;
            r_addr_low  <= i_addr_low;
            r_addr_sum  <= n_addr_sum;
            r_mac_sum   <= n_mac_sum;
        end
    end

    // Address appears twice: pseudo-header source and target field
    assign w_total = {1'b0, r_addr_sum, 1'b0} + {2'b00, r_mac_sum};
    assign w_fold1 = {1'b0, w_total[15:0]} + {12'h000, w_total[20:16]};
    assign w_fold2 = w_fold1[15:0] + {15'h0000, w_fold1[16]};

    assign o_job_valid     = r_s1_valid;
    assign o_job.addr_high = r_addr_high;
    assign o_job.addr_low  = r_addr_low;
    assign o_job.csum      = ~w_fold2;

endmodule

>>> rtl/core/unab_queue.sv
module unab_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  unab_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output unab_pkg::t_job o_rd_job
);
    import unab_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = i_rd_ready && o_rd_valid;
    assign o_rd_job   = r_mem[r_rd_ptr];

    // Store the incoming job
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/unab_back.sv
module unab_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  unab_pkg::t_job              i_job,
    input  logic [unab_pkg::MAC_W-1:0]  i_mac,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [unab_pkg::WORD_W-1:0] o_frame_word,
    output logic [unab_pkg::VB_W-1:0]   o_valid_bytes,
    output logic                        o_last_beat
);
    import unab_pkg::*;

    logic [BEAT_W-1:0] r_beat;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic [VB_W-1:0]   r_vbytes;
    logic              r_last;
    logic [WORD_W-1:0] n_word;
    logic              w_load;
    logic              w_is_last;

    assign w_load      = i_job_valid && (!r_out_valid || i_pop);
    assign w_is_last   = (r_beat == LAST_BEAT);
    assign o_job_ready = w_load && w_is_last;

    // Form the current word of the frame
    always_comb begin
        logic [15:0] a_top;
        logic [63:0] a_mid;
        logic [47:0] a_bot;
        a_top = i_job.addr_high[63:48];
        a_mid = {i_job.addr_high[47:0], i_job.addr_low[63:48]};
        a_bot = i_job.addr_low[47:0];
        case (r_beat)
            4'd0:    n_word = {MCAST_33, MCAST_33, 24'h000000, ALL_NODES, i_mac[47:32]};
            4'd1:    n_word = {i_mac[31:0], ETYPE_IPV6, IP_VER, 8'h00};
            4'd2:    n_word = {24'h000000, PAY_LEN, NH_ICMP6, HOP_LIMIT, a_top};
            4'd3:    n_word = a_mid;
            4'd4:    n_word = {a_bot, DST_PREFIX};
            4'd5:    n_word = '0;
            4'd6:    n_word = {40'h0000000000, ALL_NODES, NA_TYPE, 8'h00};
            4'd7:    n_word = {i_job.csum, NA_FLAGS, 24'h000000, a_top};
            4'd8:    n_word = a_mid;
            4'd9:    n_word = {a_bot, OPT_TLLA, OPT_LEN};
            4'd10:   n_word = {i_mac, 16'h0000};
            default: n_word = '0;
        endcase
    end

    // Advance the beat count and the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_beat      <= w_is_last ? '0 : r_beat + 4'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word   <= n_word;
            r_vbytes <= w_is_last ? TAIL_BYTES : FULL_BYTES;
            r_last   <= w_is_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_frame_word  = r_word;
    assign o_valid_bytes = r_vbytes;
    assign o_last_beat   = r_last;

endmodule

>>> rtl/core/unsolicited_neighbor_advert_builder_unit.sv
// Channel   | Handshake                   | Words
// ----------+-----------------------------+--------------------------------------------
// address   | push / full                 | i_addr_high, i_addr_low
// frame     | pop / empty                 | o_frame_word, o_valid_bytes, o_last_beat
// config    | psel, penable, pwrite       | paddr, pwdata, prdata (mac at 0x0)
//
// Each address yields eleven frame words, one per cycle from the beat sequencer while pop
// keeps up; the sequencer, not the address input, sets the rate at which addresses are served.
// The first word passes the front stage registers, the queue and the output word register.
// Reset is synchronous, active low; it clears the MAC and all valid state.
// A stalled pop holds the word; up to three addresses wait behind it.
module unsolicited_neighbor_advert_builder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [unab_pkg::ADDR_W-1:0]   i_addr_high,
    input  logic [unab_pkg::ADDR_W-1:0]   i_addr_low,
    output logic                          empty,
    input  logic                          pop,
    output logic [unab_pkg::WORD_W-1:0]   o_frame_word,
    output logic [unab_pkg::VB_W-1:0]     o_valid_bytes,
    output logic                          o_last_beat,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [unab_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import unab_pkg::*;

    logic [MAC_W-1:0] r_mac;
    logic             w_front_valid;
    logic             w_front_ready;
    t_job             w_front_job;
    logic             w_back_valid;
    logic             w_back_ready;
    t_job             w_back_job;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[3] == REG_MAC)) begin
            r_mac <= pwdata[MAC_W-1:0];
        end
    end

    assign prdata = (paddr[3] == REG_MAC) ? {16'h0000, r_mac} : 64'h0;

    unab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_addr_high (i_addr_high),
        .i_addr_low  (i_addr_low),
        .i_mac       (r_mac),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    unab_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_job   (w_front_job),
        .o_rd_valid (w_back_valid),
        .i_rd_ready (w_back_ready),
        .o_rd_job   (w_back_job)
    );

    unab_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_back_valid),
        .o_job_ready   (w_back_ready),
        .i_job         (w_back_job),
        .i_mac         (r_mac),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_frame_word  (o_frame_word),
        .o_valid_bytes (o_valid_bytes),
        .o_last_beat   (o_last_beat)
    );

endmodule
